// File: src/swpd_pkg.sv
`timescale 1ns / 1ps

package swpd_pkg;

	localparam int SINE_TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int POS_W = 30 + IDX_W;
	localparam int TAB_W = 31;
	localparam int CFG_IDX_W = 3;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30_64 = 64'd1073741824;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [63:0] RND30_POS = 64'h0000_0000_2000_0000;
	localparam logic [63:0] RND30_NEG = 64'h0000_0000_1FFF_FFFF;
	localparam logic [50:0] RND16_POS = 51'h8000;
	localparam logic [50:0] RND16_NEG = 51'h7FFF;
	localparam logic [16:0] WEIGHT_ONE = 17'h1_0000;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_AXIS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_AXIS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_WAVELENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_TURNS = 3'd4;

	typedef struct packed {
		logic [1:0]         offset_axis;
		logic [1:0]         wave_axis;
		logic signed [31:0] amplitude;
		logic [31:0]        inv_wavelength;
		logic [15:0]        phase_turns;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [16:0]        w;
		logic               bypass;
	} ctx_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [29:0]      frac;
		logic             neg;
	} ang_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} res_t;

	// quarter-wave sine in Q1.30, Taylor series, clamped and kept monotonic
	function automatic logic [TAB_W-1:0] sine_entry(input int unsigned n);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		longint      best;
		best = 0;
		for (int unsigned i = 0; i <= n; i++) begin
			x = HALF_PI_Q30 * 64'(i) / SINE_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int unsigned k = 1; k <= 8; k++) begin
				term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
				if (k[0])
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			if (sum > longint'(ONE_Q30_64))
				sum = longint'(ONE_Q30_64);
			if (sum > best)
				best = sum;
		end
		return TAB_W'(best);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [33:0] v);
		logic [31:0] r;
		if (v[33] == v[32] && v[32] == v[31])
			r = v[31:0];
		else if (v[33])
			r = 32'h8000_0000;
		else
			r = 32'h7FFF_FFFF;
		return r;
	endfunction

endpackage

// File: src/swpd_if.sv
`timescale 1ns / 1ps

interface swpd_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [16:0]        weight;

	modport source(output valid, pos_x, pos_y, pos_z, weight, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, weight, output ready);
endinterface

interface swpd_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;

	modport source(output valid, out_x, out_y, out_z, input ready);
	modport sink(input valid, out_x, out_y, out_z, output ready);
endinterface

// File: src/sine_wave_point_deformer.sv
`timescale 1ns / 1ps

// Sine wave point deformer. Moves each Q16.16 point along the configured offset
// axis by amplitude * sin(phase + coordinate * inverse_wavelength), blended by
// the point weight and saturated. Fully pipelined: one point per clock while the
// result output is not stalled (three stages for the angle, three for the table
// lookup and interpolation, five for amplitude, blend and saturation). Each stage
// holds its item while the next is full, so a stalled result blocks only the
// stages behind it. An inverse wavelength of zero or an offset axis of 3 passes
// points unchanged. Write registers only while no request is in flight.
module sine_wave_point_deformer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [swpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                       cfg_data,
	swpd_point_if.sink                        point,
	swpd_result_if.source                     result
);

	swpd_pkg::cfg_t cfg_q;

	swpd_pkg::ctx_t     in_ctx;
	logic               a_vld, a_rdy;
	swpd_pkg::ctx_t     a_ctx;
	swpd_pkg::ang_t     a_ang;
	logic               s_vld, s_rdy;
	swpd_pkg::ctx_t     s_ctx;
	logic signed [31:0] s_sin;
	swpd_pkg::res_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_axis <= swpd_pkg::AXIS_Z;
			cfg_q.wave_axis <= swpd_pkg::AXIS_X;
			cfg_q.amplitude <= 32'sd65536;
			cfg_q.inv_wavelength <= 32'd429496730;
			cfg_q.phase_turns <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				swpd_pkg::REG_OFFSET_AXIS:    cfg_q.offset_axis <= cfg_data[1:0];
				swpd_pkg::REG_WAVE_AXIS:      cfg_q.wave_axis <= cfg_data[1:0];
				swpd_pkg::REG_AMPLITUDE:      cfg_q.amplitude <= $signed(cfg_data);
				swpd_pkg::REG_INV_WAVELENGTH: cfg_q.inv_wavelength <= cfg_data;
				swpd_pkg::REG_PHASE_TURNS:    cfg_q.phase_turns <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		in_ctx.x = point.pos_x;
		in_ctx.y = point.pos_y;
		in_ctx.z = point.pos_z;
		in_ctx.w = point.weight;
		in_ctx.bypass = 1'b0;
	end

	swpd_angle u_angle (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.up_vld (point.valid),
		.up_rdy (point.ready),
		.up_ctx (in_ctx),
		.dn_vld (a_vld),
		.dn_rdy (a_rdy),
		.dn_ctx (a_ctx),
		.dn_ang (a_ang)
	);

	swpd_sine u_sine (
		.clk    (clk),
		.arst_n (arst_n),
		.up_vld (a_vld),
		.up_rdy (a_rdy),
		.up_ctx (a_ctx),
		.up_ang (a_ang),
		.dn_vld (s_vld),
		.dn_rdy (s_rdy),
		.dn_ctx (s_ctx),
		.dn_sin (s_sin)
	);

	swpd_offset u_offset (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.up_vld (s_vld),
		.up_rdy (s_rdy),
		.up_ctx (s_ctx),
		.up_sin (s_sin),
		.dn_vld (result.valid),
		.dn_rdy (result.ready),
		.dn_res (res)
	);

	assign result.out_x = res.x;
	assign result.out_y = res.y;
	assign result.out_z = res.z;

endmodule

// File: src/swpd_angle.sv
`timescale 1ns / 1ps

module swpd_angle (
	input  logic            clk,
	input  logic            arst_n,
	input  swpd_pkg::cfg_t  cfg,
	input  logic            up_vld,
	output logic            up_rdy,
	input  swpd_pkg::ctx_t  up_ctx,
	output logic            dn_vld,
	input  logic            dn_rdy,
	output swpd_pkg::ctx_t  dn_ctx,
	output swpd_pkg::ang_t  dn_ang
);

	logic vld_s1, vld_s2, vld_s3;
	logic en1, en2, en3;

	swpd_pkg::ctx_t     ctx_s1, ctx_s2, ctx_s3;
	logic signed [31:0] drive_s1;
	logic [31:0]        ang_s2;
	swpd_pkg::ang_t     ang_s3;

	swpd_pkg::ctx_t             ctx_in;
	logic signed [31:0]         drive;
	logic signed [64:0]         prod;
	logic [31:0]                angle;
	logic [30:0]                fold;
	logic [swpd_pkg::POS_W-1:0] pos;

	assign en3 = !vld_s3 || dn_rdy;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign up_rdy = en1;

	always_comb begin
		ctx_in = up_ctx;
		if (up_ctx.w > swpd_pkg::WEIGHT_ONE)
			ctx_in.w = swpd_pkg::WEIGHT_ONE;
		ctx_in.bypass = (cfg.inv_wavelength == 32'd0) || (cfg.offset_axis == swpd_pkg::AXIS_NONE);
		case (cfg.wave_axis)
			swpd_pkg::AXIS_X: drive = up_ctx.x;
			swpd_pkg::AXIS_Y: drive = up_ctx.y;
			swpd_pkg::AXIS_Z: drive = up_ctx.z;
			default:          drive = '0;
		endcase
	end

	assign prod = drive_s1 * $signed({1'b0, cfg.inv_wavelength});

	always_comb begin
		angle = ang_s2 + {cfg.phase_turns, 16'd0};
		if (angle[30])
			fold = swpd_pkg::ONE_Q30 - {1'b0, angle[29:0]};
		else
			fold = {1'b0, angle[29:0]};
		pos = swpd_pkg::POS_W'(fold) * swpd_pkg::POS_W'(swpd_pkg::SINE_TABLE_DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1)
				vld_s1 <= up_vld;
			if (en2)
				vld_s2 <= vld_s1;
			if (en3)
				vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ctx_s1 <= ctx_in;
			drive_s1 <= drive;
		end
		if (en2) begin
			ctx_s2 <= ctx_s1;
			ang_s2 <= prod[47:16];
		end
		if (en3) begin
			ctx_s3 <= ctx_s2;
			ang_s3.idx <= pos[swpd_pkg::POS_W-1:30];
			ang_s3.frac <= pos[29:0];
			ang_s3.neg <= angle[31];
		end
	end

	assign dn_vld = vld_s3;
	assign dn_ctx = ctx_s3;
	assign dn_ang = ang_s3;

endmodule

// File: src/swpd_sine.sv
`timescale 1ns / 1ps

module swpd_sine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_vld,
	output logic               up_rdy,
	input  swpd_pkg::ctx_t     up_ctx,
	input  swpd_pkg::ang_t     up_ang,
	output logic               dn_vld,
	input  logic               dn_rdy,
	output swpd_pkg::ctx_t     dn_ctx,
	output logic signed [31:0] dn_sin
);

	logic vld_s4, vld_s5, vld_s6;
	logic en4, en5, en6;

	swpd_pkg::ctx_t ctx_s4, ctx_s5, ctx_s6;

	logic [swpd_pkg::TAB_W-1:0] tab [0:swpd_pkg::SINE_TABLE_DEPTH];

	logic [swpd_pkg::IDX_W-1:0] idx_nx;
	logic [swpd_pkg::TAB_W-1:0] a, diff;
	logic [swpd_pkg::TAB_W-1:0] a_s4, diff_s4;
	logic [29:0]                frac_s4;
	logic                       neg_s4;
	logic [60:0]                ip;
	logic [swpd_pkg::TAB_W-1:0] a_s5, lo_s5;
	logic                       neg_s5;
	logic [swpd_pkg::TAB_W-1:0] v;
	logic signed [31:0]         sin_s6;

	for (genvar g = 0; g <= swpd_pkg::SINE_TABLE_DEPTH; g++) begin : g_tab
		localparam logic [swpd_pkg::TAB_W-1:0] Entry = swpd_pkg::sine_entry(g);
		assign tab[g] = Entry;
	end

	assign en6 = !vld_s6 || dn_rdy;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign up_rdy = en4;

	always_comb begin
		idx_nx = up_ang.idx + 1'b1;
		if (up_ang.idx >= swpd_pkg::IDX_W'(swpd_pkg::SINE_TABLE_DEPTH)) begin
			a = tab[swpd_pkg::SINE_TABLE_DEPTH];
			diff = '0;
		end else begin
			a = tab[up_ang.idx];
			diff = tab[idx_nx] - tab[up_ang.idx];
		end
	end

	assign ip = 61'(diff_s4) * 61'(frac_s4);
	assign v = a_s5 + lo_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en4)
				vld_s4 <= up_vld;
			if (en5)
				vld_s5 <= vld_s4;
			if (en6)
				vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			ctx_s4 <= up_ctx;
			a_s4 <= a;
			diff_s4 <= diff;
			frac_s4 <= up_ang.frac;
			neg_s4 <= up_ang.neg;
		end
		if (en5) begin
			ctx_s5 <= ctx_s4;
			a_s5 <= a_s4;
			lo_s5 <= ip[60:30];
			neg_s5 <= neg_s4;
		end
		if (en6) begin
			ctx_s6 <= ctx_s5;
			sin_s6 <= neg_s5 ? -$signed({1'b0, v}) : $signed({1'b0, v});
		end
	end

	assign dn_vld = vld_s6;
	assign dn_ctx = ctx_s6;
	assign dn_sin = sin_s6;

endmodule

// File: src/swpd_offset.sv
`timescale 1ns / 1ps

module swpd_offset (
	input  logic               clk,
	input  logic               arst_n,
	input  swpd_pkg::cfg_t     cfg,
	input  logic               up_vld,
	output logic               up_rdy,
	input  swpd_pkg::ctx_t     up_ctx,
	input  logic signed [31:0] up_sin,
	output logic               dn_vld,
	input  logic               dn_rdy,
	output swpd_pkg::res_t     dn_res
);

	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;
	logic en7, en8, en9, en10, en11;

	swpd_pkg::ctx_t ctx_s7, ctx_s8, ctx_s9, ctx_s10;

	logic signed [63:0] prod_s7;
	logic [63:0]        rnd;
	logic signed [32:0] off_s8;
	logic signed [50:0] prod2;
	logic signed [50:0] prod2_s9;
	logic [50:0]        rnd2;
	logic signed [32:0] delta_s10;
	logic signed [33:0] dx, dy, dz;
	swpd_pkg::res_t     res_s11;

	assign en11 = !vld_s11 || dn_rdy;
	assign en10 = !vld_s10 || en11;
	assign en9 = !vld_s9 || en10;
	assign en8 = !vld_s8 || en9;
	assign en7 = !vld_s7 || en8;
	assign up_rdy = en7;

	// round half away from zero: negative values add half minus one
	assign rnd = prod_s7 + (prod_s7[63] ? swpd_pkg::RND30_NEG : swpd_pkg::RND30_POS);
	assign prod2 = off_s8 * $signed({1'b0, ctx_s8.w});
	assign rnd2 = prod2_s9 + (prod2_s9[50] ? swpd_pkg::RND16_NEG : swpd_pkg::RND16_POS);

	always_comb begin
		dx = '0;
		dy = '0;
		dz = '0;
		case (cfg.offset_axis)
			swpd_pkg::AXIS_X: dx = 34'(delta_s10);
			swpd_pkg::AXIS_Y: dy = 34'(delta_s10);
			swpd_pkg::AXIS_Z: dz = 34'(delta_s10);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			if (en7)
				vld_s7 <= up_vld;
			if (en8)
				vld_s8 <= vld_s7;
			if (en9)
				vld_s9 <= vld_s8;
			if (en10)
				vld_s10 <= vld_s9;
			if (en11)
				vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en7) begin
			ctx_s7 <= up_ctx;
			prod_s7 <= cfg.amplitude * up_sin;
		end
		if (en8) begin
			ctx_s8 <= ctx_s7;
			off_s8 <= $signed(rnd[62:30]);
		end
		if (en9) begin
			ctx_s9 <= ctx_s8;
			prod2_s9 <= prod2;
		end
		if (en10) begin
			ctx_s10 <= ctx_s9;
			delta_s10 <= ctx_s9.bypass ? 33'sd0 : $signed(rnd2[48:16]);
		end
		if (en11) begin
			res_s11.x <= swpd_pkg::sat32(34'(ctx_s10.x) + dx);
			res_s11.y <= swpd_pkg::sat32(34'(ctx_s10.y) + dy);
			res_s11.z <= swpd_pkg::sat32(34'(ctx_s10.z) + dz);
		end
	end

	assign dn_vld = vld_s11;
	assign dn_res = res_s11;

endmodule
